// ===== rtl/msel_pkg.sv =====
// Shared types, constants and helper functions for the max-overlap rectangle selector.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package msel_pkg;

  localparam int MAX_CANDIDATES = 1024;
  localparam int POS_W   = $clog2(MAX_CANDIDATES + 1);
  localparam int BPOS_W  = $clog2(MAX_CANDIDATES);
  localparam int COORD_W = 32;
  localparam int SPAN_W  = 31;
  localparam int AREA_W  = 2 * SPAN_W;
  localparam int KEY_W   = AREA_W + 2;
  localparam int IDX_W   = 10;
  localparam int STAT_W  = 2;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_NONE  = 2'd0,
    ST_SEL   = 2'd1,
    ST_AMBIG = 2'd2
  } sel_status_t;

  typedef struct packed {
    logic [COORD_W-1:0] cand_left;
    logic [COORD_W-1:0] cand_top;
    logic [COORD_W-1:0] cand_right;
    logic [COORD_W-1:0] cand_bottom;
    logic               widget_flag;
    logic               ownerless_flag;
    logic               last_candidate;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] select_status;
    logic [IDX_W-1:0]  best_index;
  } out_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } rect_t;

  // classified candidate passed from front to back
  typedef struct packed {
    logic              rank_en;
    logic [SPAN_W-1:0] ov_w;
    logic [SPAN_W-1:0] ov_h;
    logic              widget;
    logic              ownerless;
    logic [BPOS_W-1:0] pos;
    logic              last;
  } entry_t;

  // hi - lo in (0, 2^31-1]
  function automatic logic span_ok(input logic [COORD_W-1:0] lo,
                                   input logic [COORD_W-1:0] hi);
    logic [COORD_W:0] d;
    d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
    return !d[COORD_W] && !d[COORD_W-1] && (|d[SPAN_W-1:0]);
  endfunction

  function automatic logic rect_ok(input rect_t r);
    return span_ok(r.left, r.right) && span_ok(r.top, r.bottom);
  endfunction

  // overlap extent of [cl,ch) and [tl,th), zero when empty
  function automatic logic [SPAN_W-1:0] ov_span(input logic [COORD_W-1:0] cl,
                                                input logic [COORD_W-1:0] ch,
                                                input logic [COORD_W-1:0] tl,
                                                input logic [COORD_W-1:0] th);
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic [COORD_W:0]   d;
    lo = ($signed(cl) > $signed(tl)) ? cl : tl;
    hi = ($signed(ch) < $signed(th)) ? ch : th;
    d  = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
    if (d[COORD_W] || !(|d[COORD_W-1:0])) begin
      return '0;
    end
    return d[SPAN_W-1:0];
  endfunction

endpackage

// ===== rtl/msel_front.sv =====
// Front end: accepts candidate words, checks validity, clips against the target
// and tracks list position. Depends on msel_pkg.
`timescale 1ns / 1ps

module msel_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  msel_pkg::in_word_t in_word,
  input  msel_pkg::rect_t   target,
  output logic              q_push,
  output msel_pkg::entry_t  q_din,
  input  logic              q_full
);
  import msel_pkg::*;

  logic [POS_W-1:0] item_pos_r;
  logic [POS_W-1:0] item_pos_nxt;
  logic             in_range;
  rect_t            cand;

  assign in_full  = q_full;
  assign q_push   = in_push && !q_full;
  assign in_range = item_pos_r < POS_W'(MAX_CANDIDATES);

  always_comb begin
    cand.left   = in_word.cand_left;
    cand.top    = in_word.cand_top;
    cand.right  = in_word.cand_right;
    cand.bottom = in_word.cand_bottom;

    q_din.rank_en   = in_range && rect_ok(target) && rect_ok(cand);
    q_din.ov_w      = ov_span(cand.left, cand.right, target.left, target.right);
    q_din.ov_h      = ov_span(cand.top, cand.bottom, target.top, target.bottom);
    q_din.widget    = in_word.widget_flag;
    q_din.ownerless = in_word.ownerless_flag;
    q_din.pos       = item_pos_r[BPOS_W-1:0];
    q_din.last      = in_word.last_candidate;
  end

  always_comb begin
    item_pos_nxt = item_pos_r;
    if (q_push) begin
      if (in_word.last_candidate) begin
        item_pos_nxt = '0;
      end else if (in_range) begin
        item_pos_nxt = item_pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_pos_r <= '0;
    end else begin
      item_pos_r <= item_pos_nxt;
    end
  end

endmodule

// ===== rtl/msel_queue.sv =====
// Short queue of classified candidates between front and back.
// Depends on msel_pkg.
`timescale 1ns / 1ps

module msel_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  msel_pkg::entry_t din,
  output logic             full,
  input  logic             pop,
  output msel_pkg::entry_t dout,
  output logic             valid
);
  import msel_pkg::*;

  entry_t          slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW-1:0] rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r;
  logic [Q_CW-1:0] cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = cnt_r == Q_CW'(Q_DEPTH);
  assign valid   = cnt_r != '0;
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CW'(do_push) - Q_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/msel_back.sv =====
// Back end: area multiply stage, rank compare against the kept best, and the
// result queue. Depends on msel_pkg.
`timescale 1ns / 1ps

module msel_back (
  input  logic               clk,
  input  logic               rst_n,
  input  msel_pkg::entry_t   q_dout,
  input  logic               q_valid,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output msel_pkg::out_word_t out_word
);
  import msel_pkg::*;

  // multiply stage
  logic              s1_v_r;
  logic              s1_rank_r;
  logic [AREA_W-1:0] s1_area_r;
  logic              s1_widget_r;
  logic              s1_own_r;
  logic [BPOS_W-1:0] s1_pos_r;
  logic              s1_last_r;

  // kept best
  logic              seen_r;
  logic              seen_nxt;
  logic              tie_r;
  logic              tie_nxt;
  logic [KEY_W-1:0]  best_key_r;
  logic [KEY_W-1:0]  best_key_nxt;
  logic [BPOS_W-1:0] best_pos_r;
  logic [BPOS_W-1:0] best_pos_nxt;

  // result queue
  out_word_t         res_r [Q_DEPTH];
  logic [Q_AW-1:0]   res_wr_r;
  logic [Q_AW-1:0]   res_rd_r;
  logic [Q_CW-1:0]   res_cnt_r;
  logic              res_push;
  logic              res_pop;
  out_word_t         res_din;

  logic [KEY_W-1:0]  key;
  logic              upd;
  logic              eq;
  logic              room;

  assign room  = (res_cnt_r + Q_CW'(s1_v_r)) < Q_CW'(Q_DEPTH);
  assign q_pop = q_valid && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_rank_r   <= q_dout.rank_en;
      s1_area_r   <= AREA_W'(q_dout.ov_w) * AREA_W'(q_dout.ov_h);
      s1_widget_r <= q_dout.widget;
      s1_own_r    <= q_dout.ownerless;
      s1_pos_r    <= q_dout.pos;
      s1_last_r   <= q_dout.last;
    end
  end

  assign key = {s1_area_r, s1_widget_r, s1_own_r};
  assign upd = s1_rank_r && (!seen_r || key > best_key_r);
  assign eq  = s1_rank_r && seen_r && key == best_key_r;

  always_comb begin
    seen_nxt     = seen_r;
    tie_nxt      = tie_r;
    best_key_nxt = best_key_r;
    best_pos_nxt = best_pos_r;
    if (upd) begin
      seen_nxt     = 1'b1;
      tie_nxt      = 1'b0;
      best_key_nxt = key;
      best_pos_nxt = s1_pos_r;
    end else if (eq) begin
      tie_nxt = 1'b1;
    end

    if (!seen_nxt) begin
      res_din.select_status = ST_NONE;
      res_din.best_index    = '0;
    end else begin
      res_din.select_status = tie_nxt ? ST_AMBIG : ST_SEL;
      res_din.best_index    = IDX_W'(best_pos_nxt);
    end
  end

  assign res_push = s1_v_r && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 1'b0;
      tie_r      <= 1'b0;
      best_key_r <= '0;
      best_pos_r <= '0;
    end else if (s1_v_r) begin
      if (s1_last_r) begin
        seen_r     <= 1'b0;
        tie_r      <= 1'b0;
        best_key_r <= '0;
        best_pos_r <= '0;
      end else begin
        seen_r     <= seen_nxt;
        tie_r      <= tie_nxt;
        best_key_r <= best_key_nxt;
        best_pos_r <= best_pos_nxt;
      end
    end
  end

  assign out_empty = res_cnt_r == '0;
  assign res_pop   = out_pop && !out_empty;
  assign out_word  = res_r[res_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (res_push) begin
        res_wr_r <= res_wr_r + Q_AW'(1);
      end
      if (res_pop) begin
        res_rd_r <= res_rd_r + Q_AW'(1);
      end
      res_cnt_r <= res_cnt_r + Q_CW'(res_push) - Q_CW'(res_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_r[res_wr_r] <= res_din;
    end
  end

endmodule

// ===== rtl/max_overlap_rect_selector.sv =====
// Top level: target registers on the APB port, front end, candidate queue, back end.
// A result passes through the candidate queue, the multiply stage and the result queue.
// Throughput: one word per cycle; each queue stalls its writer when it has no room.
// Reset: synchronous, active low; clears the target, position and best state.
// Depends on msel_pkg, msel_front, msel_queue, msel_back.
`timescale 1ns / 1ps

module max_overlap_rect_selector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  msel_pkg::in_word_t            in_word,
  output logic                          out_empty,
  input  logic                          out_pop,
  output msel_pkg::out_word_t           out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msel_pkg::ADDR_W-1:0]   paddr,
  input  logic [msel_pkg::DATA_W-1:0]   pwdata,
  output logic [msel_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import msel_pkg::*;

  rect_t    target_r;
  reg_idx_t reg_sel;
  logic     wr_en;
  logic     q_push;
  entry_t   q_din;
  logic     q_full;
  logic     q_pop;
  entry_t   q_dout;
  logic     q_valid;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_LEFT:   prdata = target_r.left;
      REG_TOP:    prdata = target_r.top;
      REG_RIGHT:  prdata = target_r.right;
      REG_BOTTOM: prdata = target_r.bottom;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_LEFT:   target_r.left   <= pwdata;
        REG_TOP:    target_r.top    <= pwdata;
        REG_RIGHT:  target_r.right  <= pwdata;
        REG_BOTTOM: target_r.bottom <= pwdata;
        default:    target_r        <= target_r;
      endcase
    end
  end

  msel_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .target  (target_r),
    .q_push  (q_push),
    .q_din   (q_din),
    .q_full  (q_full)
  );

  msel_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  msel_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_dout    (q_dout),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule
